// ===== sv/fh64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fh64_pkg
// Constants shared by the streaming 64-bit fast hash block.
// ----------------------------------------------------------------------------
package fh64_pkg;

  // Accumulator multiplier and word mix multiplier.
  localparam logic [63:0] MulConst = 64'h8803_55f2_1e6d_1965;
  localparam logic [63:0] MixConst = 64'h2127_599b_f432_5c37;

  // Shift amounts of the xor-shift mix.
  localparam int unsigned MixShiftA = 23;
  localparam int unsigned MixShiftB = 47;

  // Field widths of the stream payload.
  localparam int unsigned WordW   = 64;
  localparam int unsigned NbytesW = 4;
  localparam int unsigned LenW    = 32;
  localparam int unsigned InDataW = 104;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSeed   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNarrow = 2'd1;

endpackage

// ===== sv/fast_hash_64_stream.sv =====
`timescale 1ns / 1ps
// Each 64-bit product is formed on the shared 32x32 multiplier from three partial products
// and a drain step, and a word needs up to four of them (seed, word mix, accumulator, final
// mix). The input is not ready while a word is in progress, so a new word is taken only once
// the last one is done. The final mix also waits while the previous result still sits in the
// output register.
// Reset (rst_ni low, asynchronous) clears the seed, the mode, the sequencer and output valid.
// ----------------------------------------------------------------------------
// fast_hash_64_stream
// Streaming fasthash64 over little-endian 64-bit words, using one shared
// 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module fast_hash_64_stream (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: data_word [63:0], valid_bytes [67:64], message_length [99:68], zero pad
  input  logic [fh64_pkg::InDataW-1:0]       s_axis_tdata_i,
  // tuser: first_word [0]
  input  logic                               s_axis_tuser_i,
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: hash_value [63:0]
  output logic [63:0]                        m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fh64_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [63:0]                        cfg_data_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StMul  = 1'b1;

  localparam logic [1:0] OpInit = 2'd0;
  localparam logic [1:0] OpWord = 2'd1;
  localparam logic [1:0] OpAccm = 2'd2;
  localparam logic [1:0] OpFin  = 2'd3;

  localparam logic [1:0] PhLast = 2'd3;

  function automatic logic [63:0] pre_mix(input logic [63:0] x);
    return x ^ (x >> fh64_pkg::MixShiftA);
  endfunction

  function automatic logic [63:0] post_mix(input logic [63:0] x);
    return x ^ (x >> fh64_pkg::MixShiftB);
  endfunction

  function automatic logic [63:0] byte_mask(input logic [fh64_pkg::NbytesW-1:0] nb);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (nb > fh64_pkg::NbytesW'(i)) m[8*i +: 8] = 8'hff;
    end
    return m;
  endfunction

  // Payload unpacking.
  logic [63:0]                   in_word;
  logic [fh64_pkg::NbytesW-1:0]  in_nbytes;
  logic [fh64_pkg::LenW-1:0]     in_len;
  logic [63:0]                   in_masked;
  logic                          in_has_bytes;
  logic                          s_fire;

  assign in_word      = s_axis_tdata_i[63:0];
  assign in_nbytes    = s_axis_tdata_i[67:64];
  assign in_len       = s_axis_tdata_i[99:68];
  assign in_masked    = in_word & byte_mask(in_nbytes);
  assign in_has_bytes = (in_nbytes != '0);

  logic [63:0] seed_q;
  logic        narrow_q;
  logic [63:0] acc_q, acc_d;
  logic        in_msg_q, in_msg_d;
  logic        state_q, state_d;
  logic [1:0]  op_q, op_d;
  logic [1:0]  phase_q, phase_d;
  logic [63:0] mul_a_q, mul_a_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] sum_q, sum_d;
  logic [63:0] word_q, word_d;
  logic        has_bytes_q, has_bytes_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;

  logic [63:0] mul_const;
  logic [31:0] op_x, op_y;
  logic [63:0] mul_res;
  logic [63:0] seed_eff;
  logic [63:0] init_acc;
  logic [63:0] fin_hash;
  logic        slot_free;
  logic        fin_stall;

  assign s_axis_tready_o = (state_q == StIdle);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign fin_stall = (state_q == StMul) && (op_q == OpFin) && (phase_q == PhLast) && !slot_free;

  // Operand selection for the three partial products of a 64-bit low product.
  assign mul_const = ((op_q == OpWord) || (op_q == OpFin)) ? fh64_pkg::MixConst
                                                             : fh64_pkg::MulConst;
  always_comb begin
    case (phase_q)
      2'd1:    begin op_x = mul_a_q[63:32]; op_y = mul_const[31:0];  end
      2'd2:    begin op_x = mul_a_q[31:0];  op_y = mul_const[63:32]; end
      default: begin op_x = mul_a_q[31:0];  op_y = mul_const[31:0];  end
    endcase
  end

  assign prod_d   = {32'b0, op_x} * {32'b0, op_y};
  assign mul_res  = sum_q + {prod_q[31:0], 32'b0};
  assign seed_eff = narrow_q ? {32'b0, seed_q[31:0]} : seed_q;
  assign init_acc = seed_eff ^ mul_res;
  assign fin_hash = post_mix(mul_res);

  always_comb begin
    sum_d = sum_q;
    if (state_q == StMul && !fin_stall) begin
      if (phase_q == 2'd1) sum_d = prod_q;
      else                 sum_d = sum_q + {prod_q[31:0], 32'b0};
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    phase_d     = phase_q;
    mul_a_d     = mul_a_q;
    acc_d       = acc_q;
    in_msg_d    = in_msg_q;
    word_d      = word_q;
    has_bytes_d = has_bytes_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      StIdle: begin
        if (s_fire) begin
          word_d      = in_masked;
          has_bytes_d = in_has_bytes;
          last_d      = s_axis_tlast_i;
          phase_d     = '0;
          if (s_axis_tuser_i) begin
            in_msg_d = 1'b1;
            mul_a_d  = {32'b0, in_len};
            op_d     = OpInit;
            state_d  = StMul;
          end else if (in_msg_q) begin
            // Continuation word; a word without bytes and without last is a no-op.
            if (in_has_bytes) begin
              mul_a_d = pre_mix(in_masked);
              op_d    = OpWord;
              state_d = StMul;
            end else if (s_axis_tlast_i) begin
              mul_a_d = pre_mix(acc_q);
              op_d    = OpFin;
              state_d = StMul;
            end
          end
        end
      end
      StMul: begin
        if (phase_q != PhLast) begin
          phase_d = phase_q + 2'd1;
        end else begin
          phase_d = '0;
          unique case (op_q)
            OpInit: begin
              acc_d = init_acc;
              if (has_bytes_q) begin
                mul_a_d = pre_mix(word_q);
                op_d    = OpWord;
              end else if (last_q) begin
                mul_a_d = pre_mix(init_acc);
                op_d    = OpFin;
              end else begin
                state_d = StIdle;
              end
            end
            OpWord: begin
              mul_a_d = acc_q ^ fin_hash;
              op_d    = OpAccm;
            end
            OpAccm: begin
              acc_d = mul_res;
              if (last_q) begin
                mul_a_d = pre_mix(mul_res);
                op_d    = OpFin;
              end else begin
                state_d = StIdle;
              end
            end
            OpFin: begin
              if (slot_free) begin
                out_valid_d = 1'b1;
                out_data_d  = narrow_q ? {32'b0, fin_hash[31:0] - fin_hash[63:32]}
                                       : fin_hash;
                in_msg_d    = 1'b0;
                state_d     = StIdle;
              end else begin
                // Hold until the previous result transaction completes.
                phase_d = PhLast;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      narrow_q    <= 1'b0;
      acc_q       <= '0;
      in_msg_q    <= 1'b0;
      state_q     <= StIdle;
      op_q        <= OpInit;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      in_msg_q    <= in_msg_d;
      state_q     <= state_d;
      op_q        <= op_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          fh64_pkg::CfgSeed:   seed_q   <= cfg_data_i;
          fh64_pkg::CfgNarrow: narrow_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q     <= mul_a_d;
    word_q      <= word_d;
    has_bytes_q <= has_bytes_d;
    last_q      <= last_d;
    out_data_q  <= out_data_d;
    sum_q       <= sum_d;
    if (!fin_stall) prod_q <= prod_d;
  end

`ifndef NO_ASSERTIONS
  // The phase counter only runs while a product is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (phase_q == 2'd0))
    else $error("phase counter active while idle");

  // Multiplier work only happens inside an open message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> in_msg_q)
    else $error("sequencer busy outside a message");

  // A finished final mix always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StMul) && (op_q == OpFin) && (phase_q == PhLast) && slot_free)
      |=> (m_axis_tvalid_o && (state_q == StIdle)))
    else $error("final hash not delivered to output register");
`endif

endmodule
